// ===== rtl/tlnvf_pkg.sv =====
// Shared types and constants for the text line number and visible filter.
// Holds the transfer structs, configuration register indexes and character codes.
// No dependencies.
package tlnvf_pkg;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

	// Character codes.
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_DOLLAR   = 8'd36;
	localparam logic [7:0] CH_ZERO     = 8'd48;
	localparam logic [7:0] CH_QMARK    = 8'd63;
	localparam logic [7:0] CH_CAP_I    = 8'd73;
	localparam logic [7:0] CH_CARET    = 8'd94;
	localparam logic [7:0] CH_DELETE   = 8'd127;
	localparam logic [7:0] CTRL_MAX    = 8'd31;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;
	localparam logic [3:0] BCD_NINE    = 4'd9;

	// Input item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// Configuration register set.
	typedef struct packed {
		logic [1:0] number_mode;
		logic       squeeze_blank;
		logic       show_ends;
		logic       show_tabs;
		logic       show_nonprinting;
	} cfg_t;

	// Classified work for one input byte, apart from the number field characters.
	typedef struct packed {
		logic       num_en;
		logic       dollar_en;
		logic       caret_en;
		logic       byte_en;
		logic [7:0] byte_val;
	} job_t;

endpackage

// ===== rtl/tlnvf_front.sv =====
// Front end: configuration registers, input transfer and byte classification.
// Keeps the BCD line count and newline history and pushes work into the queue.
// Depends on tlnvf_pkg.
module tlnvf_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [tlnvf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlnvf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	input  tlnvf_pkg::in_item_t               in_data,
	output logic                              in_stall,
	input  logic                              queue_full,
	output logic                              push,
	output tlnvf_pkg::job_t                   push_job,
	output logic [NUMBER_DIGITS-1:0][7:0]     push_chars
);

	localparam int CNT_W = 4 * NUMBER_DIGITS;
	localparam logic [CNT_W-1:0] COUNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

	tlnvf_pkg::cfg_t  cfg_q;
	logic [CNT_W-1:0] count_q;
	logic             prev_nl_q;
	logic             prevprev_nl_q;

	logic             accept;
	logic [7:0]       c;
	logic             is_nl;
	logic             eff_prev;
	logic             eff_prevprev;
	logic [CNT_W-1:0] eff_count;
	logic [CNT_W-1:0] next_count;
	logic             squeezed;
	tlnvf_pkg::job_t  job;

	// Configuration writes; unlisted indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tlnvf_pkg::CFG_NUMBER_MODE:      cfg_q.number_mode      <= cfg_data;
				tlnvf_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data[0];
				tlnvf_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data[0];
				tlnvf_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data[0];
				tlnvf_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The queue is the only back pressure on the input.
	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// A first-of-file byte sees freshly reset history.
	assign c            = in_data.data_byte;
	assign is_nl        = (c == tlnvf_pkg::CH_NEWLINE);
	assign eff_prev     = in_data.first_of_file ? 1'b1 : prev_nl_q;
	assign eff_prevprev = in_data.first_of_file ? 1'b0 : prevprev_nl_q;
	assign eff_count    = in_data.first_of_file ? COUNT_ONE : count_q;
	assign squeezed     = cfg_q.squeeze_blank && is_nl && eff_prev && eff_prevprev;

	// Classify the byte into the pieces that the back end emits.
	always_comb begin
		job = '0;
		if (cfg_q.number_mode[1]) begin
			job.num_en = !is_nl && eff_prev;
		end else if (cfg_q.number_mode[0]) begin
			job.num_en = eff_prev && !squeezed;
		end
		job.dollar_en = cfg_q.show_ends && is_nl && !squeezed;
		if (cfg_q.show_tabs && c == tlnvf_pkg::CH_TAB) begin
			job.caret_en = 1'b1;
			job.byte_en  = 1'b1;
			job.byte_val = tlnvf_pkg::CH_CAP_I;
		end else if (!squeezed) begin
			job.byte_en  = 1'b1;
			job.byte_val = c;
			if (cfg_q.show_nonprinting && c <= tlnvf_pkg::CTRL_MAX &&
			    c != tlnvf_pkg::CH_TAB && c != tlnvf_pkg::CH_NEWLINE) begin
				job.caret_en = 1'b1;
				job.byte_val = c + tlnvf_pkg::CTRL_OFFSET;
			end else if (cfg_q.show_nonprinting && c == tlnvf_pkg::CH_DELETE) begin
				job.caret_en = 1'b1;
				job.byte_val = tlnvf_pkg::CH_QMARK;
			end
		end
	end

	// Number field characters, most significant digit first, leading zeros blanked.
	always_comb begin
		logic       blank;
		logic [3:0] dig;
		blank = 1'b1;
		for (int p = 0; p < NUMBER_DIGITS; p++) begin
			dig = eff_count[4*(NUMBER_DIGITS-1-p) +: 4];
			if (dig != 4'd0 || p == NUMBER_DIGITS - 1) begin
				blank = 1'b0;
			end
			push_chars[p] = blank ? tlnvf_pkg::CH_SPACE : (tlnvf_pkg::CH_ZERO | {4'd0, dig});
		end
	end

	// Saturating BCD increment: a digit steps when all lower digits are nine.
	always_comb begin
		logic       carry;
		logic       all_nines;
		logic [3:0] dig;
		carry      = 1'b1;
		all_nines  = 1'b1;
		next_count = eff_count;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			dig = eff_count[4*i +: 4];
			if (dig != tlnvf_pkg::BCD_NINE) begin
				all_nines = 1'b0;
			end
			if (carry) begin
				next_count[4*i +: 4] = (dig == tlnvf_pkg::BCD_NINE) ? 4'd0 : dig + 4'd1;
			end
			carry = carry && (dig == tlnvf_pkg::BCD_NINE);
		end
		if (all_nines) begin
			next_count = eff_count;
		end
	end

	// Line count and newline history update on each input transfer; the count steps only when numbered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= COUNT_ONE;
			prev_nl_q     <= 1'b1;
			prevprev_nl_q <= 1'b0;
		end else if (accept) begin
			count_q       <= job.num_en ? next_count : eff_count;
			prev_nl_q     <= is_nl;
			prevprev_nl_q <= eff_prev;
		end
	end

	// Bytes that produce nothing never enter the queue.
	assign push     = accept && (job.num_en || job.dollar_en || job.caret_en || job.byte_en);
	assign push_job = job;

`ifndef SYNTH
	for (genvar g = 0; g < NUMBER_DIGITS; g++) begin : g_bcd_chk
		a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[4*g +: 4] <= tlnvf_pkg::BCD_NINE)
			else $error("line count digit is not a valid BCD digit");
	end
`endif

endmodule

// ===== rtl/tlnvf_queue.sv =====
// Short work queue between the classifier and the emitter.
// Register-based storage with read and write pointers and an entry count.
// No package dependencies.
module tlnvf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/tlnvf_back.sv =====
// Back end: takes classified work from the queue and emits one byte per cycle while the output is not stalled.
// A pending-piece mask selects the next byte; an output register feeds the result channel.
// Depends on tlnvf_pkg.
module tlnvf_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  tlnvf_pkg::job_t               job,
	input  logic [NUMBER_DIGITS-1:0][7:0] job_chars,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tlnvf_pkg::out_item_t          out_data
);

	// Piece order: digits, number tab, dollar, caret, byte.
	localparam int POS_TAB    = NUMBER_DIGITS;
	localparam int POS_DOLLAR = NUMBER_DIGITS + 1;
	localparam int POS_CARET  = NUMBER_DIGITS + 2;
	localparam int POS_BYTE   = NUMBER_DIGITS + 3;
	localparam int NSEG       = NUMBER_DIGITS + 4;

	logic                          cur_valid_q;
	logic [NSEG-1:0]               mask_q;
	logic [NUMBER_DIGITS-1:0][7:0] chars_q;
	logic [7:0]                    byte_q;
	logic                          out_valid_q;
	tlnvf_pkg::out_item_t          out_q;

	logic                          advance;
	logic                          emit;
	logic                          done;
	logic [NSEG-1:0]               sel;
	logic [NSEG-1:0]               rest;
	logic [NSEG-1:0]               load_mask;
	logic [7:0]                    sel_byte;

	assign advance = !out_valid_q || !out_stall;
	assign sel     = mask_q & (~mask_q + 1'b1);
	assign rest    = mask_q & ~sel;
	assign emit    = cur_valid_q && advance;
	assign done    = emit && (rest == '0);
	assign pop     = job_valid && (!cur_valid_q || done);

	// Pending pieces of a newly loaded job.
	always_comb begin
		load_mask             = '0;
		load_mask[POS_TAB:0]  = {(NUMBER_DIGITS+1){job.num_en}};
		load_mask[POS_DOLLAR] = job.dollar_en;
		load_mask[POS_CARET]  = job.caret_en;
		load_mask[POS_BYTE]   = job.byte_en;
	end

	// Byte of the selected piece.
	always_comb begin
		sel_byte = '0;
		for (int p = 0; p < NUMBER_DIGITS; p++) begin
			sel_byte = sel_byte | (chars_q[p] & {8{sel[p]}});
		end
		sel_byte = sel_byte | (tlnvf_pkg::CH_TAB    & {8{sel[POS_TAB]}});
		sel_byte = sel_byte | (tlnvf_pkg::CH_DOLLAR & {8{sel[POS_DOLLAR]}});
		sel_byte = sel_byte | (tlnvf_pkg::CH_CARET  & {8{sel[POS_CARET]}});
		sel_byte = sel_byte | (byte_q               & {8{sel[POS_BYTE]}});
	end

	// Current job: load from the queue as the previous one finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			mask_q      <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			mask_q      <= load_mask;
		end else if (done) begin
			cur_valid_q <= 1'b0;
			mask_q      <= '0;
		end else if (emit) begin
			mask_q      <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			chars_q <= job_chars;
			byte_q  <= job.byte_val;
		end
	end

	// Output register toward the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte <= sel_byte;
			out_q.last     <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_cur_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (mask_q != '0))
		else $error("emitter holds a job with no pending bytes");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid && (load_mask != '0))
		else $error("emitter took an empty or absent job");
	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pop |=> !cur_valid_q)
		else $error("job still active after its last byte");
`endif

endmodule

// ===== rtl/text_line_number_visible_filter.sv =====
// Path: an input item is written into the work queue, loaded into the emitter's job
// register, and its bytes leave through the output register. Throughput: one result
// byte per cycle while the output is not stalled; meanwhile a four-entry work queue absorbs the input.
// Items that produce no bytes never enter the queue or reach the emitter.
// Reset: configuration registers clear to zero, the line count to one, and the
// newline history to "previous byte was a newline".
module text_line_number_visible_filter #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [tlnvf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlnvf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tlnvf_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output tlnvf_pkg::out_item_t              out_data
);

	localparam int QUEUE_DEPTH = 4;
	localparam int CHARS_W     = 8 * NUMBER_DIGITS;
	localparam int ENTRY_W     = $bits(tlnvf_pkg::job_t) + CHARS_W;

	logic                          push;
	tlnvf_pkg::job_t               push_job;
	logic [NUMBER_DIGITS-1:0][7:0] push_chars;
	logic                          queue_full;
	logic                          queue_not_empty;
	logic                          pop;
	logic [ENTRY_W-1:0]            pop_entry;
	tlnvf_pkg::job_t               head_job;
	logic [NUMBER_DIGITS-1:0][7:0] head_chars;

	// Classifier.
	tlnvf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.in_stall   (in_stall),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job),
		.push_chars (push_chars)
	);

	// Work queue.
	tlnvf_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_job, push_chars}),
		.pop       (pop),
		.pop_data  (pop_entry),
		.full      (queue_full),
		.not_empty (queue_not_empty)
	);

	assign head_job   = pop_entry[ENTRY_W-1:CHARS_W];
	assign head_chars = pop_entry[CHARS_W-1:0];

	// Emitter.
	tlnvf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_not_empty),
		.job       (head_job),
		.job_chars (head_chars),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== bench/tlnvf_stream_checker.sv =====
// Stream checker for the text line number and visible filter: mirrors the
// register file, predicts the filtered byte stream and compares every output transfer.
// Depends on tlnvf_pkg for the transfer structs, register indexes and character codes.
module tlnvf_stream_checker
	import tlnvf_pkg::*;
#(
	parameter int DIGITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_data,
	output int                    mismatch_count,
	output int                    bytes_pending
);

	localparam int PRINT_CAP = 100;
	localparam logic [4*DIGITS-1:0] BCD_ONE = {{(4*DIGITS-1){1'b0}}, 1'b1};

	// Mirrored registers, line counter and newline history.
	cfg_t              shadow_cfg;
	logic [4*DIGITS-1:0] line_bcd;
	logic              after_nl;
	logic              after_two_nl;
	out_item_t         filtered_bytes_q[$];

	initial mismatch_count = 0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Works out the bytes that one input byte turns into and queues them in order.
	task automatic filter_byte(input in_item_t item);
		logic [7:0] c;
		logic [7:0] seq[$];
		logic [3:0] dig;
		logic       is_nl;
		logic       squeezed;
		logic       numbered;
		logic       lead;
		logic       all_nines;
		logic       carry;
		out_item_t  exp_item;
		c = item.data_byte;
		is_nl = (c == CH_NEWLINE);
		if (item.first_of_file) begin
			line_bcd = BCD_ONE;
			after_nl = 1'b1;
			after_two_nl = 1'b0;
		end
		squeezed = shadow_cfg.squeeze_blank && is_nl && after_nl && after_two_nl;

		// Bit 1 of the number mode selects nonblank numbering and wins over bit 0.
		if (shadow_cfg.number_mode[1]) begin
			numbered = !is_nl && after_nl;
		end else begin
			numbered = shadow_cfg.number_mode[0] && after_nl && !squeezed;
		end

		// Right-aligned line number padded with spaces, then a tab.
		if (numbered) begin
			lead = 1'b1;
			for (int d = DIGITS - 1; d >= 0; d--) begin
				dig = line_bcd[4*d +: 4];
				if (dig != 4'd0 || d == 0) begin
					lead = 1'b0;
				end
				seq.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, dig});
			end
			seq.push_back(CH_TAB);

			// The BCD count sticks once every digit is a nine.
			all_nines = 1'b1;
			for (int d = 0; d < DIGITS; d++) begin
				if (line_bcd[4*d +: 4] != BCD_NINE) begin
					all_nines = 1'b0;
				end
			end
			carry = !all_nines;
			for (int d = 0; d < DIGITS; d++) begin
				if (carry) begin
					if (line_bcd[4*d +: 4] == BCD_NINE) begin
						line_bcd[4*d +: 4] = 4'd0;
					end else begin
						line_bcd[4*d +: 4] = line_bcd[4*d +: 4] + 4'd1;
						carry = 1'b0;
					end
				end
			end
		end

		if (shadow_cfg.show_ends && is_nl && !squeezed) begin
			seq.push_back(CH_DOLLAR);
		end

		// Tab expansion, caret notation, then the byte itself.
		if (shadow_cfg.show_tabs && c == CH_TAB) begin
			seq.push_back(CH_CARET);
			seq.push_back(CH_CAP_I);
		end else if (!squeezed) begin
			if (shadow_cfg.show_nonprinting && c <= CTRL_MAX && c != CH_TAB && c != CH_NEWLINE) begin
				seq.push_back(CH_CARET);
				c = c + CTRL_OFFSET;
			end else if (shadow_cfg.show_nonprinting && c == CH_DELETE) begin
				seq.push_back(CH_CARET);
				c = CH_QMARK;
			end
			seq.push_back(c);
		end

		after_two_nl = after_nl;
		after_nl = is_nl;

		foreach (seq[i]) begin
			exp_item.out_byte = seq[i];
			exp_item.last = (i == seq.size() - 1);
			filtered_bytes_q.push_back(exp_item);
		end
	endtask

	// Register writes, output comparison and input prediction, all on the sampling edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			shadow_cfg = '0;
			line_bcd = BCD_ONE;
			after_nl = 1'b1;
			after_two_nl = 1'b0;
			filtered_bytes_q.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_NUMBER_MODE:      shadow_cfg.number_mode = cfg_data[1:0];
					CFG_SQUEEZE_BLANK:    shadow_cfg.squeeze_blank = cfg_data[0];
					CFG_SHOW_ENDS:        shadow_cfg.show_ends = cfg_data[0];
					CFG_SHOW_TABS:        shadow_cfg.show_tabs = cfg_data[0];
					CFG_SHOW_NONPRINTING: shadow_cfg.show_nonprinting = cfg_data[0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (filtered_bytes_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						out_data.out_byte, out_data.last));
				end else begin
					exp_item = filtered_bytes_q.pop_front();
					if (out_data.out_byte !== exp_item.out_byte) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_data.out_byte, exp_item.out_byte));
					end
					if (out_data.last !== exp_item.last) begin
						report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
							out_data.last, exp_item.out_byte, exp_item.last));
					end
				end
			end

			if (in_valid && !in_stall) begin
				filter_byte(in_data);
			end
		end
		bytes_pending = filtered_bytes_q.size();
	end

endmodule

// ===== bench/text_line_number_visible_filter_tb.sv =====
// Testbench top for the text line number and visible filter: clock, reset, register
// writes, byte stimulus with random pacing on both channels, watchdog and verdict.
// Depends on tlnvf_pkg, the filter RTL and tlnvf_stream_checker.
module text_line_number_visible_filter_tb;
	import tlnvf_pkg::*;

	localparam int FILTER_DIGITS   = 6;
	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 62;

	// Number mode settings.
	localparam logic [1:0] NUM_OFF      = 2'd0;
	localparam logic [1:0] NUM_ALL      = 2'd1;
	localparam logic [1:0] NUM_NONBLANK = 2'd2;
	localparam logic [1:0] NUM_BOTH     = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	in_item_t              in_data = '0;
	logic                  out_stall = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	out_item_t             out_data;
	int                    mismatch_count;
	int                    bytes_pending;

	bit tx_gaps_on = 1'b0;
	bit rx_gaps_on = 1'b0;
	bit hold_off_req = 1'b0;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	text_line_number_visible_filter #(
		.NUMBER_DIGITS(FILTER_DIGITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	tlnvf_stream_checker #(
		.DIGITS(FILTER_DIGITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.bytes_pending  (bytes_pending)
	);

	// Gap length: mostly none, often short, now and then long.
	function automatic int gap_length();
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	// One byte of line content, weighted toward printable text.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		int r;
		r = $urandom_range(99);
		if (r < 55) begin
			b = 8'($urandom_range(32, 126));
		end else if (r < 65) begin
			b = CH_TAB;
		end else if (r < 75) begin
			b = 8'($urandom_range(0, 31));
		end else if (r < 80) begin
			b = CH_DELETE;
		end else if (r < 92) begin
			b = 8'($urandom_range(128, 255));
		end else begin
			b = 8'($urandom_range(255));
		end
		return b;
	endfunction

	// Offers one byte and returns at the edge where its transfer happens.
	task automatic send_byte(input logic [7:0] b, input logic fof);
		int   gap;
		logic stalled;
		gap = tx_gaps_on ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, first_of_file: fof};
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	// Lets the filter drain; a squeezed newline produces nothing and never enters the queue.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (bytes_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Writes every register, with a random upper bit on the one-bit ones,
	// plus a write to an index past the register list.
	task automatic load_settings(input cfg_t s);
		write_reg(CFG_NUMBER_MODE, s.number_mode);
		write_reg(CFG_SQUEEZE_BLANK, {$urandom_range(1) != 0, s.squeeze_blank});
		write_reg(CFG_SHOW_ENDS, {$urandom_range(1) != 0, s.show_ends});
		write_reg(CFG_SHOW_TABS, {$urandom_range(1) != 0, s.show_tabs});
		write_reg(CFG_SHOW_NONPRINTING, {$urandom_range(1) != 0, s.show_nonprinting});
		write_reg(CFG_IDX_W'($urandom_range(CFG_SHOW_NONPRINTING + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1)));
		cfg_wen <= 1'b0;
	endtask

	// Receiver pacing: a long hold-off on request, otherwise random stalls when enabled.
	always begin : receiver_pacing
		int n;
		@(posedge clk);
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			out_stall <= 1'b1;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			out_stall <= 1'b0;
		end else if (rx_gaps_on) begin
			n = gap_length();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no transfer and no register write.
	always @(negedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("text_line_number_visible_filter verification failed");
			$finish;
		end else if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Directed cases, then random text under a series of register settings.
	initial begin
		cfg_t s;
		int   sent;
		int   len;
		int   r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: everything passes through raw, the high bytes included.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_DELETE, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		wait_idle();

		// All options on, with number mode three behaving as nonblank numbering.
		load_settings(cfg_t'{NUM_BOTH, 1'b1, 1'b1, 1'b1, 1'b1});
		send_byte(8'h41, 1'b1);
		send_byte(CH_TAB, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(CTRL_MAX, 1'b0);
		send_byte(CH_DELETE, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		wait_idle();

		// Every line numbered: a squeezed newline gets no number, controls go out raw.
		load_settings(cfg_t'{NUM_ALL, 1'b1, 1'b1, 1'b0, 1'b0});
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(8'h1B, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();

		// Random phases: mostly lines of text and blank runs, some raw noise.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: s = cfg_t'{NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1};
				1: s = cfg_t'{NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0};
				2: s = cfg_t'{NUM_ALL, 1'b1, 1'b0, 1'b1, 1'b0};
				default: begin
					s.number_mode = 2'($urandom_range(NUM_BOTH));
					s.squeeze_blank = 1'($urandom_range(1));
					s.show_ends = 1'($urandom_range(1));
					s.show_tabs = 1'($urandom_range(1));
					s.show_nonprinting = 1'($urandom_range(1));
				end
			endcase
			load_settings(s);
			tx_gaps_on = p[0];
			rx_gaps_on = p[1];
			if (p == 3 || p == 6) begin
				hold_off_req = 1'b1;
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(9);
				if (r < 7) begin
					len = $urandom_range(0, 12);
					for (int i = 0; i < len; i++) begin
						send_byte(text_byte(), i == 0 && $urandom_range(15) == 0);
					end
					send_byte(CH_NEWLINE, len == 0 && $urandom_range(15) == 0);
					sent += len + 1;
				end else if (r == 7) begin
					len = $urandom_range(2, 5);
					repeat (len) send_byte(CH_NEWLINE, 1'b0);
					sent += len;
				end else begin
					len = $urandom_range(1, 4);
					repeat (len) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
					sent += len;
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0 && bytes_pending == 0) begin
			$display("text_line_number_visible_filter verification clean");
		end else begin
			$display("text_line_number_visible_filter verification failed");
		end
		$finish;
	end

endmodule

// ===== text_line_number_visible_filter.f =====
rtl/tlnvf_pkg.sv
rtl/tlnvf_front.sv
rtl/tlnvf_queue.sv
rtl/tlnvf_back.sv
rtl/text_line_number_visible_filter.sv
bench/tlnvf_stream_checker.sv
bench/text_line_number_visible_filter_tb.sv
